// ===== hdl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants for the line crossing counter
// Fixed field widths, datapath widths, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package lcc_pkg;

    // field widths
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 2;
    localparam int VCOUNT_W  = 16;
    localparam int CFG_IDX_W = 2;

    // datapath widths
    localparam int DIFF_W  = COORD_W + 1;      // coordinate differences
    localparam int OPND_W  = DIFF_W + 1;       // multiplier operands
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 52;               // accumulator
    localparam int CROSS_W = 2 * DIFF_W;       // side cross products (signed)
    localparam int MAG_W   = CROSS_W - 1;      // magnitude of a cross product
    localparam int SPLIT_W = 17;               // low slice of the split multiply
    localparam int NUM_W   = 50;               // dividend |d1| * |num|
    localparam int DEN_W   = MAG_W + 2;        // |cb| + |cf|
    localparam int QUO_W   = COORD_W;          // rounded offset magnitude
    localparam int REM_W   = 52;               // divider remainder

    // repeat suppression radius, in fraction units
    localparam int FRAC_BITS     = 4;
    localparam int REPEAT_PIXELS = 4;
    localparam int RADIUS        = REPEAT_PIXELS << FRAC_BITS;
    localparam int RADIUS_SQ     = RADIUS * RADIUS;

    typedef enum logic [OUT_W-1:0] {
        OUT_SKIPPED  = 2'd0,
        OUT_NO_CROSS = 2'd1,
        OUT_COUNTED  = 2'd2,
        OUT_REPEAT   = 2'd3
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_A_X = 2'd0,
        REG_LINE_A_Y = 2'd1,
        REG_LINE_B_X = 2'd2,
        REG_LINE_B_Y = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CB0,
        ST_CB1,
        ST_CF0,
        ST_CF1,
        ST_SIDE,
        ST_MX0,
        ST_MX1,
        ST_DIVX,
        ST_WAITX,
        ST_MY0,
        ST_MY1,
        ST_DIVY,
        ST_WAITY,
        ST_BOX,
        ST_DD0,
        ST_DD1,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic en;    // update accumulator
        logic clr;   // start from zero
        logic sub;   // subtract the term
        logic shl;   // term shifted up by SPLIT_W
    } mac_ctrl_t;

endpackage

// ===== hdl/lcc_mac.sv =====
// ----------------------------------------------------------------------------
// lcc_mac: shared multiply-accumulate unit
// One signed 18x18 multiply per cycle, added to or subtracted from a wide
// accumulator, optionally shifted up for split multiplies.
// ----------------------------------------------------------------------------
module lcc_mac (
    input  logic                              clk,
    input  lcc_pkg::mac_ctrl_t                ctrl,
    input  logic signed [lcc_pkg::OPND_W-1:0] op_a,
    input  logic signed [lcc_pkg::OPND_W-1:0] op_b,
    output logic signed [lcc_pkg::ACC_W-1:0]  acc
);
    import lcc_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb begin
        prod = op_a * op_b;
        term = ctrl.shl ? (ACC_W'(prod) <<< SPLIT_W) : ACC_W'(prod);
        base = ctrl.clr ? '0 : acc_reg;
        if (ctrl.en) begin
            acc_next = ctrl.sub ? (base - term) : (base + term);
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== hdl/lcc_div.sv =====
// ----------------------------------------------------------------------------
// lcc_div: iterative rounding divider
// quot = floor((2*numer + denom) / (2*denom)), one quotient bit per cycle.
// The quotient must fit QUO_W bits; the caller guarantees it.
// ----------------------------------------------------------------------------
module lcc_div (
    input  logic                            clk,
    input  logic                            rstn,
    input  logic                            start,
    input  logic [lcc_pkg::NUM_W-1:0]       numer,
    input  logic [lcc_pkg::DEN_W-1:0]       denom,
    output logic                            busy,
    output logic                            done,
    output logic [lcc_pkg::QUO_W-1:0]       quot
);
    import lcc_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quot_reg, quot_next;
    logic [REM_W:0]   diff;
    logic             ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        diff      = {1'b0, rem_reg} - {1'b0, dsh_reg};
        ge        = ~diff[REM_W];
        if (start) begin
            // the half-divisor bias gives round-half-up on magnitudes
            rem_next  = (REM_W'(numer) << 1) + REM_W'(denom);
            dsh_next  = (REM_W'(denom) << 1) << (QUO_W - 1);
            quot_next = '0;
            cnt_next  = CNT_W'(QUO_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = diff[REM_W-1:0];
            end
            quot_next = {quot_reg[QUO_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hdl/line_crossing_counter_unit.sv =====
// ----------------------------------------------------------------------------
// line_crossing_counter_unit: counts tracked points crossing a set line
// Side test, segment intersection and repeat check for one point at a time,
// on a shared multiply-accumulate unit and an iterative divider.
// ----------------------------------------------------------------------------
// A skipped point goes straight to the result; a point that does not change
// sides ends after the side test; a side change runs two 16-step divisions.
// One point at a time: a new point is taken only when idle, which can be while
// the previous result still waits on the output register.
// Reset (aresetn low, synchronous): line registers, last crossing point and
// count cleared to zero, both channels empty.
// ----------------------------------------------------------------------------
module line_crossing_counter_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // point input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_point_valid,
    input  logic signed [lcc_pkg::COORD_W-1:0]    s_before_x,
    input  logic signed [lcc_pkg::COORD_W-1:0]    s_before_y,
    input  logic signed [lcc_pkg::COORD_W-1:0]    s_after_x,
    input  logic signed [lcc_pkg::COORD_W-1:0]    s_after_y,
    input  logic                                  s_last_point,
    // result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lcc_pkg::OUT_W-1:0]             m_outcome,
    output logic [lcc_pkg::VCOUNT_W-1:0]          m_vehicle_count,
    output logic                                  m_frame_end,
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lcc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic signed [lcc_pkg::COORD_W-1:0]    cfg_data
);
    import lcc_pkg::*;

    // control state
    state_t                    state_reg, state_next;
    logic                      m_valid_reg, m_valid_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic signed [COORD_W-1:0] last_x_reg, last_x_next;
    logic signed [COORD_W-1:0] last_y_reg, last_y_next;
    logic signed [COORD_W-1:0] line_ax_reg, line_ax_next;
    logic signed [COORD_W-1:0] line_ay_reg, line_ay_next;
    logic signed [COORD_W-1:0] line_bx_reg, line_bx_next;
    logic signed [COORD_W-1:0] line_by_reg, line_by_next;

    // per-transaction working registers
    logic signed [COORD_W-1:0] bx_reg, bx_next;
    logic signed [COORD_W-1:0] by_reg, by_next;
    logic signed [DIFF_W-1:0]  d1x_reg, d1x_next;
    logic signed [DIFF_W-1:0]  d1y_reg, d1y_next;
    logic signed [DIFF_W-1:0]  d2x_reg, d2x_next;
    logic signed [DIFF_W-1:0]  d2y_reg, d2y_next;
    logic signed [DIFF_W-1:0]  wbx_reg, wbx_next;
    logic signed [DIFF_W-1:0]  wby_reg, wby_next;
    logic signed [DIFF_W-1:0]  wfx_reg, wfx_next;
    logic signed [DIFF_W-1:0]  wfy_reg, wfy_next;
    logic signed [CROSS_W-1:0] cb_reg, cb_next;
    logic [MAG_W-1:0]          cbmag_reg, cbmag_next;
    logic [MAG_W-1:0]          cfmag_reg, cfmag_next;
    logic [COORD_W-1:0]        d1xmag_reg, d1xmag_next;
    logic [COORD_W-1:0]        d1ymag_reg, d1ymag_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic signed [DIFF_W-1:0]  px_reg, px_next;
    logic signed [DIFF_W-1:0]  py_reg, py_next;
    logic signed [OPND_W-1:0]  ddx_reg, ddx_next;
    logic signed [OPND_W-1:0]  ddy_reg, ddy_next;
    outcome_t                  outcome_reg, outcome_next;
    logic                      frame_reg, frame_next;

    // output payload
    outcome_t                  m_outcome_reg, m_outcome_next;
    logic [VCOUNT_W-1:0]       m_count_reg, m_count_next;
    logic                      m_frame_reg, m_frame_next;

    // shared units
    mac_ctrl_t                 mac_ctrl;
    logic signed [OPND_W-1:0]  op_a, op_b;
    logic signed [ACC_W-1:0]   acc;
    logic                      div_start, div_busy, div_done;
    logic [QUO_W-1:0]          quot;

    logic signed [CROSS_W-1:0] cf_w;
    logic                      opposite;
    logic signed [DIFF_W-1:0]  qs_w;
    logic signed [DIFF_W-1:0]  ax_w, ay_w, ex_w, ey_w;
    logic                      in_x, in_y;

    lcc_mac u_mac (
        .clk  (aclk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    lcc_div u_div (
        .clk   (aclk),
        .rstn  (aresetn),
        .start (div_start),
        .numer (acc[NUM_W-1:0]),
        .denom (den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    assign cf_w = acc[CROSS_W-1:0];
    // strictly opposite sides of the counting line; implies a nonzero denominator
    assign opposite = (cb_reg != '0) && (cf_w != '0) &&
                      (cb_reg[CROSS_W-1] != cf_w[CROSS_W-1]);

    assign ax_w = DIFF_W'(line_ax_reg);
    assign ay_w = DIFF_W'(line_ay_reg);
    assign ex_w = DIFF_W'(line_bx_reg);
    assign ey_w = DIFF_W'(line_by_reg);
    assign in_x = ((ax_w <= px_reg) && (px_reg <= ex_w)) ||
                  ((ex_w <= px_reg) && (px_reg <= ax_w));
    assign in_y = ((ay_w <= py_reg) && (py_reg <= ey_w)) ||
                  ((ey_w <= py_reg) && (py_reg <= ay_w));

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        count_next    = count_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        line_ax_next  = line_ax_reg;
        line_ay_next  = line_ay_reg;
        line_bx_next  = line_bx_reg;
        line_by_next  = line_by_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        d1x_next      = d1x_reg;
        d1y_next      = d1y_reg;
        d2x_next      = d2x_reg;
        d2y_next      = d2y_reg;
        wbx_next      = wbx_reg;
        wby_next      = wby_reg;
        wfx_next      = wfx_reg;
        wfy_next      = wfy_reg;
        cb_next       = cb_reg;
        cbmag_next    = cbmag_reg;
        cfmag_next    = cfmag_reg;
        d1xmag_next   = d1xmag_reg;
        d1ymag_next   = d1ymag_reg;
        den_next      = den_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        ddx_next      = ddx_reg;
        ddy_next      = ddy_reg;
        outcome_next  = outcome_reg;
        frame_next    = frame_reg;
        m_outcome_next = m_outcome_reg;
        m_count_next  = m_count_reg;
        m_frame_next  = m_frame_reg;
        mac_ctrl      = '0;
        op_a          = '0;
        op_b          = '0;
        div_start     = 1'b0;
        qs_w          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_LINE_A_X: line_ax_next = cfg_data;
                REG_LINE_A_Y: line_ay_next = cfg_data;
                REG_LINE_B_X: line_bx_next = cfg_data;
                REG_LINE_B_Y: line_by_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bx_next    = s_before_x;
                    by_next    = s_before_y;
                    d1x_next   = DIFF_W'(s_after_x) - DIFF_W'(s_before_x);
                    d1y_next   = DIFF_W'(s_after_y) - DIFF_W'(s_before_y);
                    d2x_next   = ex_w - ax_w;
                    d2y_next   = ey_w - ay_w;
                    wbx_next   = ax_w - DIFF_W'(s_before_x);
                    wby_next   = ay_w - DIFF_W'(s_before_y);
                    wfx_next   = ax_w - DIFF_W'(s_after_x);
                    wfy_next   = ay_w - DIFF_W'(s_after_y);
                    frame_next = s_last_point;
                    if (s_point_valid) begin
                        state_next = ST_CB0;
                    end else begin
                        outcome_next = OUT_SKIPPED;
                        state_next   = ST_DONE;
                    end
                end
            end
            // side value of a point: (A - p).x * d2.y - (A - p).y * d2.x
            ST_CB0: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
                op_a       = OPND_W'(wbx_reg);
                op_b       = OPND_W'(d2y_reg);
                state_next = ST_CB1;
            end
            ST_CB1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b1, shl: 1'b0};
                op_a       = OPND_W'(wby_reg);
                op_b       = OPND_W'(d2x_reg);
                state_next = ST_CF0;
            end
            ST_CF0: begin
                cb_next    = acc[CROSS_W-1:0];
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
                op_a       = OPND_W'(wfx_reg);
                op_b       = OPND_W'(d2y_reg);
                state_next = ST_CF1;
            end
            ST_CF1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b1, shl: 1'b0};
                op_a       = OPND_W'(wfy_reg);
                op_b       = OPND_W'(d2x_reg);
                state_next = ST_SIDE;
            end
            // num = cb, den = cb - cf; with opposite signs |den| = |cb| + |cf|
            ST_SIDE: begin
                if (opposite) begin
                    cbmag_next  = cb_reg[CROSS_W-1] ? MAG_W'(-cb_reg) : MAG_W'(cb_reg);
                    cfmag_next  = cf_w[CROSS_W-1] ? MAG_W'(-cf_w) : MAG_W'(cf_w);
                    d1xmag_next = d1x_reg[DIFF_W-1] ? COORD_W'(-d1x_reg) : COORD_W'(d1x_reg);
                    d1ymag_next = d1y_reg[DIFF_W-1] ? COORD_W'(-d1y_reg) : COORD_W'(d1y_reg);
                    state_next  = ST_MX0;
                end else begin
                    outcome_next = OUT_NO_CROSS;
                    state_next   = ST_DONE;
                end
            end
            ST_MX0: begin
                den_next   = DEN_W'(cbmag_reg) + DEN_W'(cfmag_reg);
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
                op_a       = $signed(OPND_W'(cbmag_reg[SPLIT_W-1:0]));
                op_b       = $signed(OPND_W'(d1xmag_reg));
                state_next = ST_MX1;
            end
            ST_MX1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b1};
                op_a       = $signed(OPND_W'(cbmag_reg[MAG_W-1:SPLIT_W]));
                op_b       = $signed(OPND_W'(d1xmag_reg));
                state_next = ST_DIVX;
            end
            ST_DIVX: begin
                div_start  = 1'b1;
                state_next = ST_WAITX;
            end
            ST_WAITX: begin
                if (div_done) begin
                    qs_w       = d1x_reg[DIFF_W-1] ? -$signed(DIFF_W'(quot))
                                                   : $signed(DIFF_W'(quot));
                    px_next    = DIFF_W'(bx_reg) + qs_w;
                    state_next = ST_MY0;
                end
            end
            ST_MY0: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
                op_a       = $signed(OPND_W'(cbmag_reg[SPLIT_W-1:0]));
                op_b       = $signed(OPND_W'(d1ymag_reg));
                state_next = ST_MY1;
            end
            ST_MY1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b1};
                op_a       = $signed(OPND_W'(cbmag_reg[MAG_W-1:SPLIT_W]));
                op_b       = $signed(OPND_W'(d1ymag_reg));
                state_next = ST_DIVY;
            end
            ST_DIVY: begin
                div_start  = 1'b1;
                state_next = ST_WAITY;
            end
            ST_WAITY: begin
                if (div_done) begin
                    qs_w       = d1y_reg[DIFF_W-1] ? -$signed(DIFF_W'(quot))
                                                   : $signed(DIFF_W'(quot));
                    py_next    = DIFF_W'(by_reg) + qs_w;
                    state_next = ST_BOX;
                end
            end
            ST_BOX: begin
                if (in_x && in_y) begin
                    ddx_next   = OPND_W'(px_reg) - OPND_W'(last_x_reg);
                    ddy_next   = OPND_W'(py_reg) - OPND_W'(last_y_reg);
                    state_next = ST_DD0;
                end else begin
                    outcome_next = OUT_NO_CROSS;
                    state_next   = ST_DONE;
                end
            end
            ST_DD0: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
                op_a       = ddx_reg;
                op_b       = ddx_reg;
                state_next = ST_DD1;
            end
            ST_DD1: begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b0};
                op_a       = ddy_reg;
                op_b       = ddy_reg;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (acc < $signed(ACC_W'(RADIUS_SQ))) begin
                    // repeat: forget the stored point
                    last_x_next  = '0;
                    last_y_next  = '0;
                    outcome_next = OUT_REPEAT;
                end else begin
                    last_x_next  = px_reg[COORD_W-1:0];
                    last_y_next  = py_reg[COORD_W-1:0];
                    if (~&count_reg) begin
                        count_next = count_reg + 1'b1;
                    end
                    outcome_next = OUT_COUNTED;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_outcome_next = outcome_reg;
                    m_count_next   = VCOUNT_W'(count_reg);
                    m_frame_next   = frame_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            line_ax_reg <= '0;
            line_ay_reg <= '0;
            line_bx_reg <= '0;
            line_by_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            line_ax_reg <= line_ax_next;
            line_ay_reg <= line_ay_next;
            line_bx_reg <= line_bx_next;
            line_by_reg <= line_by_next;
        end
    end

    always_ff @(posedge aclk) begin
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        d1x_reg       <= d1x_next;
        d1y_reg       <= d1y_next;
        d2x_reg       <= d2x_next;
        d2y_reg       <= d2y_next;
        wbx_reg       <= wbx_next;
        wby_reg       <= wby_next;
        wfx_reg       <= wfx_next;
        wfy_reg       <= wfy_next;
        cb_reg        <= cb_next;
        cbmag_reg     <= cbmag_next;
        cfmag_reg     <= cfmag_next;
        d1xmag_reg    <= d1xmag_next;
        d1ymag_reg    <= d1ymag_next;
        den_reg       <= den_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        ddx_reg       <= ddx_next;
        ddy_reg       <= ddy_next;
        outcome_reg   <= outcome_next;
        frame_reg     <= frame_next;
        m_outcome_reg <= m_outcome_next;
        m_count_reg   <= m_count_next;
        m_frame_reg   <= m_frame_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_outcome       = m_outcome_reg;
    assign m_vehicle_count = m_count_reg;
    assign m_frame_end     = m_frame_reg;

    // divider is only started when idle
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // one transaction at a time on the input
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a point is in work");

    // a counted result implies a nonzero running count
    a_counted_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_outcome == OUT_COUNTED) |-> (count_reg != '0))
        else $error("counted result with zero count");

    // the count never goes down outside reset
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (count_reg >= $past(count_reg)))
        else $error("crossing count decreased");

endmodule

// ===== verif/line_crossing_checker.sv =====
// ----------------------------------------------------------------------------
// line_crossing_checker: result predictor and scoreboard for the line crossing
// counter. Watches the register, point and result channels. Keeps its own
// copy of the counting line, the last crossing point and the count. Compares
// every result with the oldest expected one.
// ----------------------------------------------------------------------------
module line_crossing_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_point_valid,
    input  logic signed [lcc_pkg::COORD_W-1:0]    s_before_x,
    input  logic signed [lcc_pkg::COORD_W-1:0]    s_before_y,
    input  logic signed [lcc_pkg::COORD_W-1:0]    s_after_x,
    input  logic signed [lcc_pkg::COORD_W-1:0]    s_after_y,
    input  logic                                  s_last_point,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [lcc_pkg::OUT_W-1:0]             m_outcome,
    input  logic [lcc_pkg::VCOUNT_W-1:0]          m_vehicle_count,
    input  logic                                  m_frame_end,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [lcc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic signed [lcc_pkg::COORD_W-1:0]    cfg_data,
    output int unsigned                           fail_count,
    output int unsigned                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcc_pkg::*;

    localparam longint COUNT_MAX     = (longint'(1) << COUNT_WIDTH) - 1;
    localparam longint REPEAT_RADIUS = 4 << 4;   // 4 pixels, 1/16 pixel units

    typedef struct {
        outcome_t                outcome;
        logic [VCOUNT_W-1:0]     count;
        logic                    frame_end;
    } tally_t;

    tally_t expected_q[$];

    longint line_ax, line_ay, line_bx, line_by;
    longint last_x, last_y;
    longint total;

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        fail_count++;
    endtask

    // nearest integer, halves away from zero
    function automatic longint round_quot(longint n, longint d);
        if (d < 0) begin
            d = -d;
            n = -n;
        end
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic int side_of(longint px, longint py);
        longint c;
        c = (line_bx - line_ax) * (py - line_ay) - (line_by - line_ay) * (px - line_ax);
        return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    function automatic bit within_span(longint v, longint e0, longint e1);
        return (e0 <= v && v <= e1) || (e1 <= v && v <= e0);
    endfunction

    function automatic tally_t predict_point(logic pv,
                                             logic signed [COORD_W-1:0] bx_i,
                                             logic signed [COORD_W-1:0] by_i,
                                             logic signed [COORD_W-1:0] fx_i,
                                             logic signed [COORD_W-1:0] fy_i,
                                             logic lp);
        tally_t res;
        longint bx, by, fx, fy, d1x, d1y, d2x, d2y, wx, wy, den, num, px, py, ddx, ddy;
        res.outcome = OUT_NO_CROSS;
        if (!pv) begin
            res.outcome = OUT_SKIPPED;
        end else begin
            bx = bx_i;
            by = by_i;
            fx = fx_i;
            fy = fy_i;
            d1x = fx - bx;
            d1y = fy - by;
            d2x = line_bx - line_ax;
            d2y = line_by - line_ay;
            wx = line_ax - bx;
            wy = line_ay - by;
            den = d1x * d2y - d1y * d2x;
            if (den != 0) begin
                num = wx * d2y - wy * d2x;
                px = bx + round_quot(d1x * num, den);
                py = by + round_quot(d1y * num, den);
                if (within_span(px, line_ax, line_bx) && within_span(py, line_ay, line_by)
                        && side_of(bx, by) * side_of(fx, fy) < 0) begin
                    ddx = px - last_x;
                    ddy = py - last_y;
                    if (ddx * ddx + ddy * ddy < REPEAT_RADIUS * REPEAT_RADIUS) begin
                        // repeat: stored point falls back to the origin
                        last_x = 0;
                        last_y = 0;
                        res.outcome = OUT_REPEAT;
                    end else begin
                        last_x = px;
                        last_y = py;
                        if (total < COUNT_MAX)
                            total++;
                        res.outcome = OUT_COUNTED;
                    end
                end
            end
        end
        res.count = total[VCOUNT_W-1:0];
        res.frame_end = lp;
        return res;
    endfunction

    always @(posedge aclk) begin
        tally_t want;
        if (!aresetn) begin
            line_ax = 0;
            line_ay = 0;
            line_bx = 0;
            line_by = 0;
            last_x = 0;
            last_y = 0;
            total = 0;
            fail_count = 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LINE_A_X: line_ax = cfg_data;
                    REG_LINE_A_Y: line_ay = cfg_data;
                    REG_LINE_B_X: line_bx = cfg_data;
                    REG_LINE_B_Y: line_by = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict_point(s_point_valid, s_before_x, s_before_y,
                                                   s_after_x, s_after_y, s_last_point));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result transaction with nothing pending: outcome %0d count %0d",
                                              m_outcome, m_vehicle_count));
                end else begin
                    want = expected_q.pop_front();
                    if (m_outcome !== want.outcome)
                        report_mismatch($sformatf("outcome got %0d want %0d (%s)",
                                                  m_outcome, want.outcome, want.outcome.name()));
                    if (m_vehicle_count !== want.count)
                        report_mismatch($sformatf("vehicle_count got %0d want %0d",
                                                  m_vehicle_count, want.count));
                    if (m_frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %0b want %0b",
                                                  m_frame_end, want.frame_end));
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== verif/line_crossing_counter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// line_crossing_counter_unit_tb: stimulus and verdict for the crossing counter
// Sets several counting lines, the extremes among them. Sends directed points
// first, then random motion around each line, with random gaps and stalls.
// ----------------------------------------------------------------------------
module line_crossing_counter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 7;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_point_valid = 1'b0;
    logic signed [COORD_W-1:0]  s_before_x = '0;
    logic signed [COORD_W-1:0]  s_before_y = '0;
    logic signed [COORD_W-1:0]  s_after_x = '0;
    logic signed [COORD_W-1:0]  s_after_y = '0;
    logic                       s_last_point = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [OUT_W-1:0]           m_outcome;
    logic [VCOUNT_W-1:0]        m_vehicle_count;
    logic                       m_frame_end;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic signed [COORD_W-1:0]  cfg_data = '0;

    int unsigned fail_count;
    int unsigned pending;
    int          stall_cycles = 0;
    int          hold_requests = 0;
    int          holds_done = 0;
    bit          steady_sender = 1'b0;

    // current counting line and the last generated crossing point
    int cur_ax, cur_ay, cur_bx, cur_by;
    int near_x = 0, near_y = 0;

    line_crossing_counter_unit dut (.*);

    line_crossing_checker checker_i (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: random ready pattern, plus a long hold-off on request
    initial begin
        int r;
        @(posedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 40)) @(posedge aclk);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(20, 80)) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [COORD_W-1:0] clamp16(int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[COORD_W-1:0];
    endfunction

    function automatic int rand_span(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic pause_sender();
        int r, gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!steady_sender && r >= 55)
            gap = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // one point transaction, then a random gap; valid stays high when no gap
    task automatic send_point(bit pv, int bx, int by, int fx, int fy, bit lp);
        s_point_valid <= pv;
        s_before_x <= clamp16(bx);
        s_before_y <= clamp16(by);
        s_after_x <= clamp16(fx);
        s_after_y <= clamp16(fy);
        s_last_point <= lp;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pause_sender();
    endtask

    // drain: all results back before the line registers change
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int value);
        cfg_index <= idx;
        cfg_data <= value[COORD_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_line(int ax, int ay, int bx, int by);
        cur_ax = ax;
        cur_ay = ay;
        cur_bx = bx;
        cur_by = by;
        write_reg(REG_LINE_A_X, ax);
        write_reg(REG_LINE_A_Y, ay);
        write_reg(REG_LINE_B_X, bx);
        write_reg(REG_LINE_B_Y, by);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_point();
        int pick, qx, qy, ox, oy, k, r;
        bit lp;
        pick = $urandom_range(0, 99);
        lp = ($urandom_range(0, 7) == 0);
        if (pick < 65) begin
            // motion through a point on the segment, or close to the last one
            if (pick < 15) begin
                qx = near_x + rand_span(30);
                qy = near_y + rand_span(30);
            end else begin
                k = $urandom_range(0, 1024);
                qx = cur_ax + (cur_bx - cur_ax) * k / 1024;
                qy = cur_ay + (cur_by - cur_ay) * k / 1024;
            end
            case ($urandom_range(0, 3))
                0: r = 24;
                1: r = 200;
                2: r = 3000;
                default: r = 20000;
            endcase
            ox = rand_span(r);
            oy = rand_span(r);
            k = $urandom_range(1, 8);
            near_x = qx;
            near_y = qy;
            send_point(1'b1, qx + ox, qy + oy, qx - ox * k / 4, qy - oy * k / 4, lp);
        end else if (pick < 80) begin
            send_point(1'b1, rand_coord(), rand_coord(), rand_coord(), rand_coord(), lp);
        end else if (pick < 88) begin
            send_point(1'b0, rand_coord(), rand_coord(), rand_coord(), rand_coord(), lp);
        end else begin
            qx = rand_coord();
            qy = rand_coord();
            case ($urandom_range(0, 2))
                0: send_point(1'b1, qx, qy, qx + cur_bx - cur_ax, qy + cur_by - cur_ay, lp);
                1: begin
                    // motion ending exactly on an endpoint of the line
                    ox = rand_span(500);
                    oy = rand_span(500);
                    if ($urandom_range(0, 1))
                        send_point(1'b1, cur_ax + ox, cur_ay + oy, cur_ax, cur_ay, lp);
                    else
                        send_point(1'b1, cur_bx + ox, cur_by + oy, cur_bx, cur_by, lp);
                end
                default: send_point(1'b1, qx, qy, qx, qy, lp);
            endcase
        end
    endtask

    initial begin
        int lines[PHASES][4];
        int n_items;
        lines = '{'{-32768, -32768, 32767, 32767},
                  '{0, -4000, 0, 4000},
                  '{32767, -32768, -32768, 32767},
                  '{1234, -1234, 1234, -1234},
                  '{-3000, 1200, 2500, -700},
                  '{32767, 32767, -32768, -32768},
                  '{0, 0, 0, 0}};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed points on a horizontal line
        set_line(-1600, 0, 1600, 0);
        send_point(1'b0, -32768, 32767, 32767, -32768, 1'b1);   // skipped
        send_point(1'b1, 320, -160, 320, 160, 1'b0);             // counted
        send_point(1'b1, 320, -160, 320, 160, 1'b1);             // repeat
        send_point(1'b1, 32, -16, 32, 16, 1'b0);                 // near origin after reset
        send_point(1'b1, 100, -16, 100, 16, 1'b0);               // counted
        send_point(1'b1, 160, 16, 160, -16, 1'b0);               // repeat
        send_point(1'b1, 0, 100, 500, 100, 1'b1);                // parallel
        send_point(1'b1, 10, 10, 10, 10, 1'b0);                  // no motion
        send_point(1'b1, 500, -50, 500, 0, 1'b0);                // ends on the line
        send_point(1'b1, 500, 0, 500, 50, 1'b0);                 // starts on the line
        send_point(1'b1, 2000, -10, 2000, 10, 1'b0);             // outside the box
        send_point(1'b1, 1600, -10, 1600, 10, 1'b1);             // box edge
        send_point(1'b1, -800, 300, -800, -300, 1'b0);           // downward crossing
        send_point(1'b1, 700, 10, 700, 50, 1'b0);                // same side
        send_point(1'b1, -32768, -32768, 32767, 32767, 1'b0);
        send_point(1'b1, 32767, -32768, -32768, 32767, 1'b1);
        send_point(1'b1, 1000, -1, 1001, 1, 1'b0);               // half rounds up
        send_point(1'b1, -1000, -1, -1001, 1, 1'b0);             // half rounds away from zero
        send_point(1'b1, 32767, 32767, -32768, -32768, 1'b1);
        send_point(1'b1, -32768, 1, -32768, -1, 1'b0);           // outside box, far left
        settle();

        // the listed lines, the all-zero reset value among them, then a random one
        for (int p = 0; p <= PHASES; p++) begin
            if (p == PHASES)
                set_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            else
                set_line(lines[p][0], lines[p][1], lines[p][2], lines[p][3]);
            steady_sender = (p % 3 == 2);
            if (p == 1)
                hold_requests++;
            n_items = (p == 3 || p == 6) ? 25 : 70;
            for (int i = 0; i < n_items; i++)
                random_point();
            settle();
        end

        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== line_crossing_counter_unit.f =====
hdl/lcc_pkg.sv
hdl/lcc_mac.sv
hdl/lcc_div.sv
hdl/line_crossing_counter_unit.sv
verif/line_crossing_checker.sv
verif/line_crossing_counter_unit_tb.sv
